/* design/sfts_pkg.sv */
// Package with shared constants, types and codes of the tick scheduler.
`timescale 1ns / 1ps
package sfts_pkg;
  localparam int NUM_TASKS_DEF = 1;
  localparam int NUM_USER_PROCS_DEF = 7;
  localparam int NUM_SEMAPHORES_DEF = 4;
  localparam int MS_PER_SECOND = 1000;
  localparam int SLEEP_SCALE = 10;

  localparam logic [2:0] ACT_WAIT = 3'd0;
  localparam logic [2:0] ACT_SIGNAL = 3'd1;
  localparam logic [2:0] ACT_SLEEP = 3'd2;
  localparam logic [2:0] ACT_RESCHED = 3'd3;
  localparam logic [2:0] ACT_LOAD = 3'd4;

  localparam logic [2:0] CFG_SEM_A = 3'd0;
  localparam logic [2:0] CFG_SEM_D = 3'd3;
  localparam logic [2:0] CFG_TICK_RATE = 3'd4;

  typedef struct packed {
    logic       start;
  } scan_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic       found;
    logic [3:0] idx;
  } scan_stat_t;
endpackage

/* design/sfts_if.sv */
// Valid-ready channel interfaces for the input and result transactions.
`timescale 1ns / 1ps
interface sfts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [1:0]  sem_index;
  logic [15:0] sleep_ms;
  logic [2:0]  proc_index;
  logic [15:0] new_ticks;
  logic [15:0] new_priority;
  logic [19:0] new_sleeping;
  logic        new_blocked;
  modport source (output valid, action, sem_index, sleep_ms, proc_index, new_ticks,
                  new_priority, new_sleeping, new_blocked, input ready);
  modport sink (input valid, action, sem_index, sleep_ms, proc_index, new_ticks,
                new_priority, new_sleeping, new_blocked, output ready);
endinterface

interface sfts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] running_proc;
  logic       none_ready;
  logic       caller_blocked;
  logic       woken_valid;
  logic [2:0] woken_proc;
  modport source (output valid, running_proc, none_ready, caller_blocked, woken_valid,
                  woken_proc, input ready);
  modport sink (input valid, running_proc, none_ready, caller_blocked, woken_valid,
                woken_proc, output ready);
endinterface

/* design/sfts_scan.sv */
// Sequential scan unit that finds the best runnable process one entry per cycle.
`timescale 1ns / 1ps
module sfts_scan
  import sfts_pkg::*;
#(
  parameter int NPROC = NUM_TASKS_DEF + NUM_USER_PROCS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_cmd_t        cmd,
  input  logic [15:0]      slice,
  input  logic             eligible,
  output logic [3:0]       rd_idx,
  output scan_stat_t       stat
);
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  best_idx_r, best_idx_nxt;
  logic [15:0] best_r, best_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    idx_nxt = idx_r;
    best_idx_nxt = best_idx_r;
    best_nxt = best_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      idx_nxt = '0;
      best_nxt = '0;
      best_idx_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (eligible && (slice > best_r)) begin
        best_nxt = slice;
        best_idx_nxt = idx_r;
      end
      if (idx_r == 4'(NPROC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      idx_r <= idx_nxt;
    end
    best_r <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign rd_idx = idx_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.found = (best_r != '0);
  assign stat.idx = best_idx_r;
endmodule

/* design/semaphore_fifo_tick_scheduler_core.sv */
// Top level of the semaphore FIFO tick scheduler.
`timescale 1ns / 1ps
// The block takes one system call transaction at a time and returns one result
// transaction for each. Wait, signal and load pass from acceptance through the
// execute state to the output state, and the block can take its next transaction
// in the cycle after the result leaves. A sleep, a reschedule or a blocking wait
// runs the shared scan unit over the process table, one entry per cycle, and a
// second pass after the refill when the first finds nothing. The sleep conversion
// is a reciprocal multiply followed by a multiply by the tick rate and sleep scale.
module semaphore_fifo_tick_scheduler_core
  import sfts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int NUM_USER_PROCS = NUM_USER_PROCS_DEF,
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  sfts_in_if.sink     in_ch,
  sfts_out_if.source  out_ch
);
  localparam int NPROC = NUM_TASKS + NUM_USER_PROCS;
  localparam int QW = (NUM_USER_PROCS > 1) ? $clog2(NUM_USER_PROCS) : 1;
  localparam int PW = (NPROC > 1) ? $clog2(NPROC) : 1;
  localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam logic [16:0] MS_RECIP = 17'd67109;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_REFILL = 3'd3;
  localparam logic [2:0] ST_SCAN2 = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;
  localparam logic [2:0] ST_SLEEPMUL = 3'd6;

  logic [2:0]  state_r;
  logic [15:0] slice_left_r [NPROC];
  logic [15:0] slice_refill_r [NPROC];
  logic [19:0] sleep_left_r [NPROC];
  logic [NPROC-1:0] blocked_r;
  logic [PW-1:0] cur_r;
  logic signed [4:0] sem_count_r [NUM_SEMAPHORES];
  logic [QW-1:0] head_r [NUM_SEMAPHORES];
  logic [QW-1:0] tail_r [NUM_SEMAPHORES];
  logic [PW-1:0] ring_r [NUM_SEMAPHORES][NUM_USER_PROCS];
  logic [9:0]  tick_rate_r;

  logic [2:0]  act_r;
  logic [1:0]  sem_r;
  logic [15:0] ms_r;
  logic [2:0]  pi_r;
  logic [15:0] nt_r, np_r;
  logic [19:0] ns_r;
  logic        nb_r;
  logic [6:0]  secs_r;

  logic [2:0]  o_wp_r;
  logic        o_none_r, o_blk_r, o_wv_r;

  scan_cmd_t  scmd;
  scan_stat_t sstat;
  logic [3:0] rd_idx;
  logic [PW-1:0] rd_p;
  logic [15:0] rd_slice;
  logic        rd_elig;

  assign rd_p = rd_idx[PW-1:0];
  assign rd_slice = slice_left_r[rd_p];
  assign rd_elig = (sleep_left_r[rd_p] == '0) && !blocked_r[rd_p];

  sfts_scan #(.NPROC(NPROC)) u_scan (
    .clk(clk), .rst_n(rst_n), .cmd(scmd), .slice(rd_slice),
    .eligible(rd_elig), .rd_idx(rd_idx), .stat(sstat)
  );

  logic sem_ok;
  logic [SW-1:0] sem_sel;
  logic [SW-1:0] cfg_sel;
  logic signed [4:0] sc;
  logic [PW-1:0] wp;
  logic [32:0] recip;
  logic [29:0] prod;
  assign sem_ok = 32'(sem_r) < NUM_SEMAPHORES;
  assign sem_sel = SW'(sem_r);
  assign cfg_sel = SW'(cfg_index[1:0]);
  assign sc = sem_count_r[sem_sel];
  assign wp = ring_r[sem_sel][head_r[sem_sel]];
  assign recip = 33'(ms_r) * 33'(MS_RECIP);
  assign prod = 30'(secs_r) * 30'(tick_rate_r) * 30'(SLEEP_SCALE);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.running_proc = 3'(cur_r);
  assign out_ch.none_ready = o_none_r;
  assign out_ch.caller_blocked = o_blk_r;
  assign out_ch.woken_valid = o_wv_r;
  assign out_ch.woken_proc = o_wp_r;

  always_comb begin
    scmd.start = 1'b0;
    if (state_r == ST_REFILL) scmd.start = 1'b1;
    if (state_r == ST_SLEEPMUL) scmd.start = 1'b1;
    if (state_r == ST_EXEC && (act_r == ACT_RESCHED ||
        (act_r == ACT_WAIT && sem_ok && (sc == -5'sd16 || sc - 5'sd1 < 0))))
      scmd.start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r <= '0;
      blocked_r <= '0;
      tick_rate_r <= 10'd100;
      for (int s = 0; s < NUM_SEMAPHORES; s++) begin
        sem_count_r[s] <= 5'sd1;
        head_r[s] <= '0;
        tail_r[s] <= '0;
      end
      for (int i = 0; i < NPROC; i++) begin
        slice_left_r[i] <= '0;
        slice_refill_r[i] <= '0;
        sleep_left_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index <= CFG_SEM_D) begin
          if (32'(cfg_index) < NUM_SEMAPHORES) begin
            sem_count_r[cfg_sel] <= $signed({1'b0, cfg_data[3:0]});
            head_r[cfg_sel] <= '0;
            tail_r[cfg_sel] <= '0;
          end
        end else if (cfg_index == CFG_TICK_RATE) begin
          tick_rate_r <= cfg_data;
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            state_r <= ST_EXEC;
            o_none_r <= 1'b0;
            o_blk_r <= 1'b0;
            o_wv_r <= 1'b0;
            o_wp_r <= '0;
          end
        end
        ST_EXEC: begin
          state_r <= ST_OUT;
          if (act_r == ACT_WAIT && sem_ok) begin
            if (sc != -5'sd16) sem_count_r[sem_sel] <= sc - 5'sd1;
            if (sc == -5'sd16 || sc - 5'sd1 < 0) begin
              blocked_r[cur_r] <= 1'b1;
              ring_r[sem_sel][tail_r[sem_sel]] <= cur_r;
              tail_r[sem_sel] <=
                (tail_r[sem_sel] == QW'(NUM_USER_PROCS - 1)) ? '0 :
                tail_r[sem_sel] + 1'b1;
              o_blk_r <= 1'b1;
              state_r <= ST_SCAN;
            end
          end else if (act_r == ACT_SIGNAL && sem_ok) begin
            if (sc != 5'sd15) sem_count_r[sem_sel] <= sc + 5'sd1;
            if (sc != 5'sd15 && sc + 5'sd1 <= 0) begin
              if (32'(wp) < NPROC) blocked_r[wp] <= 1'b0;
              o_wp_r <= 3'(wp);
              o_wv_r <= 1'b1;
              head_r[sem_sel] <=
                (head_r[sem_sel] == QW'(NUM_USER_PROCS - 1)) ? '0 :
                head_r[sem_sel] + 1'b1;
            end
          end else if (act_r == ACT_SLEEP) begin
            state_r <= ST_SLEEPMUL;
          end else if (act_r == ACT_RESCHED) begin
            state_r <= ST_SCAN;
          end else if (act_r == ACT_LOAD && 32'(pi_r) < NPROC) begin
            slice_left_r[pi_r[PW-1:0]] <= nt_r;
            slice_refill_r[pi_r[PW-1:0]] <= np_r;
            sleep_left_r[pi_r[PW-1:0]] <= ns_r;
            blocked_r[pi_r[PW-1:0]] <= nb_r;
          end
        end
        ST_SLEEPMUL: begin
          sleep_left_r[cur_r] <= prod[19:0];
          state_r <= ST_SCAN;
        end
        ST_SCAN, ST_SCAN2: begin
          if (sstat.done) begin
            if (sstat.found) begin
              cur_r <= sstat.idx[PW-1:0];
              state_r <= ST_OUT;
            end else if (state_r == ST_SCAN) begin
              state_r <= ST_REFILL;
            end else begin
              o_none_r <= 1'b1;
              state_r <= ST_OUT;
            end
          end
        end
        ST_REFILL: begin
          for (int i = 0; i < NPROC; i++)
            if (slice_left_r[i] == '0) slice_left_r[i] <= slice_refill_r[i];
          state_r <= ST_SCAN2;
        end
        ST_OUT: begin
          if (out_ch.ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    if (state_r == ST_IDLE) begin
      act_r <= in_ch.action;
      sem_r <= in_ch.sem_index;
      ms_r <= in_ch.sleep_ms;
      pi_r <= in_ch.proc_index;
      nt_r <= in_ch.new_ticks;
      np_r <= in_ch.new_priority;
      ns_r <= in_ch.new_sleeping;
      nb_r <= in_ch.new_blocked;
    end
    if (state_r == ST_EXEC) secs_r <= recip[32:26];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("accepting while a result is pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REFILL) |=> sstat.busy) else $error("second scan did not start");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(o_blk_r && o_wv_r)) else $error("blocked and woken together");
endmodule

/* test/testbench.sv */
// Testbench that drives scheduler system calls and checks each result against a local predictor.
`timescale 1ns / 1ps
module testbench;
  import sfts_pkg::*;

  localparam int NPROC = NUM_TASKS_DEF + NUM_USER_PROCS_DEF;
  localparam int NRING = NUM_USER_PROCS_DEF;
  localparam int NSEM = NUM_SEMAPHORES_DEF;
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST = 3'd7;

  typedef struct {
    logic [2:0]  action;
    logic [1:0]  sem_index;
    logic [15:0] sleep_ms;
    logic [2:0]  proc_index;
    logic [15:0] new_ticks;
    logic [15:0] new_priority;
    logic [19:0] new_sleeping;
    logic        new_blocked;
  } syscall_t;

  typedef struct {
    logic [2:0] running_proc;
    logic       none_ready;
    logic       caller_blocked;
    logic       woken_valid;
    logic [2:0] woken_proc;
  } sched_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [9:0] cfg_data;

  sfts_in_if in_if();
  sfts_out_if out_if();

  semaphore_fifo_tick_scheduler_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_if), .out_ch(out_if)
  );

  syscall_t pending_calls[$];
  sched_result_t expected_results[$];
  syscall_t cur_call;
  int errors = 0;
  bit idling_on = 1;
  int send_gap = 0;
  int stall_left = 0;

  logic [15:0] slice_left[NPROC];
  logic [15:0] slice_refill[NPROC];
  logic [19:0] sleep_left[NPROC];
  logic        proc_blocked[NPROC];
  logic [2:0]  running_idx;
  int          sem_count[NSEM];
  int          ring_head[NSEM];
  int          ring_tail[NSEM];
  logic [2:0]  waiter_ring[NSEM][NRING];
  int unsigned tick_rate;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic bit pick_runnable();
    int unsigned best;
    int idx;
    best = 0;
    idx = 0;
    for (int i = 0; i < NPROC; i++) begin
      if (sleep_left[i] == 0 && !proc_blocked[i] && slice_left[i] > best) begin
        best = slice_left[i];
        idx = i;
      end
    end
    if (best == 0) return 1'b0;
    running_idx = idx[2:0];
    return 1'b1;
  endfunction

  function automatic logic run_scheduler();
    if (pick_runnable()) return 1'b0;
    for (int i = 0; i < NPROC; i++)
      if (slice_left[i] == 0) slice_left[i] = slice_refill[i];
    if (pick_runnable()) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void apply_config(logic [2:0] idx, logic [9:0] val);
    if (idx <= CFG_SEM_D) begin
      sem_count[idx] = int'(val[3:0]);
      ring_head[idx] = 0;
      ring_tail[idx] = 0;
    end else if (idx == CFG_TICK_RATE) begin
      tick_rate = val;
    end
  endfunction

  function automatic void schedule_call(syscall_t c);
    sched_result_t r;
    int s;
    r = '{3'd0, 1'b0, 1'b0, 1'b0, 3'd0};
    s = c.sem_index;
    case (c.action)
      ACT_WAIT: begin
        if (sem_count[s] > -16) sem_count[s]--;
        if (sem_count[s] < 0) begin
          proc_blocked[running_idx] = 1'b1;
          waiter_ring[s][ring_tail[s]] = running_idx;
          ring_tail[s] = (ring_tail[s] + 1) % NRING;
          r.caller_blocked = 1'b1;
          r.none_ready = run_scheduler();
        end
      end
      ACT_SIGNAL: begin
        if (sem_count[s] < 15) sem_count[s]++;
        if (sem_count[s] <= 0) begin
          r.woken_proc = waiter_ring[s][ring_head[s]];
          proc_blocked[r.woken_proc] = 1'b0;
          ring_head[s] = (ring_head[s] + 1) % NRING;
          r.woken_valid = 1'b1;
        end
      end
      ACT_SLEEP: begin
        sleep_left[running_idx] = 20'((int'(c.sleep_ms) / MS_PER_SECOND) * tick_rate
                                      * SLEEP_SCALE);
        r.none_ready = run_scheduler();
      end
      ACT_RESCHED: r.none_ready = run_scheduler();
      ACT_LOAD: begin
        slice_left[c.proc_index] = c.new_ticks;
        slice_refill[c.proc_index] = c.new_priority;
        sleep_left[c.proc_index] = c.new_sleeping;
        proc_blocked[c.proc_index] = c.new_blocked;
      end
      default: ;
    endcase
    r.running_proc = running_idx;
    expected_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) schedule_call(cur_call);
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_calls.size() > 0) begin
          cur_call = pending_calls.pop_front();
          in_if.action <= cur_call.action;
          in_if.sem_index <= cur_call.sem_index;
          in_if.sleep_ms <= cur_call.sleep_ms;
          in_if.proc_index <= cur_call.proc_index;
          in_if.new_ticks <= cur_call.new_ticks;
          in_if.new_priority <= cur_call.new_priority;
          in_if.new_sleeping <= cur_call.new_sleeping;
          in_if.new_blocked <= cur_call.new_blocked;
          in_if.valid <= 1'b1;
          if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    sched_result_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction running_proc=%0d", $time,
                   out_if.running_proc);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_if.running_proc !== e.running_proc) begin
            $display("%0t: running_proc expected %0d actual %0d", $time, e.running_proc,
                     out_if.running_proc);
            errors++;
          end
          if (out_if.none_ready !== e.none_ready) begin
            $display("%0t: none_ready expected %0d actual %0d", $time, e.none_ready,
                     out_if.none_ready);
            errors++;
          end
          if (out_if.caller_blocked !== e.caller_blocked) begin
            $display("%0t: caller_blocked expected %0d actual %0d", $time, e.caller_blocked,
                     out_if.caller_blocked);
            errors++;
          end
          if (out_if.woken_valid !== e.woken_valid) begin
            $display("%0t: woken_valid expected %0d actual %0d", $time, e.woken_valid,
                     out_if.woken_valid);
            errors++;
          end
          if (out_if.woken_proc !== e.woken_proc) begin
            $display("%0t: woken_proc expected %0d actual %0d", $time, e.woken_proc,
                     out_if.woken_proc);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic syscall_t make_call(logic [2:0] act, logic [1:0] sem, logic [15:0] ms,
                                         logic [2:0] pi, logic [15:0] tk, logic [15:0] pr,
                                         logic [19:0] sl, logic bl);
    syscall_t c;
    c = '{act, sem, ms, pi, tk, pr, sl, bl};
    return c;
  endfunction

  function automatic syscall_t random_call();
    syscall_t c;
    int pick;
    c.sem_index = $urandom_range(0, 3);
    c.proc_index = $urandom_range(0, 7);
    c.sleep_ms = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4999))
                                             : 16'($urandom_range(0, 65535));
    c.new_ticks = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(0, 20));
    c.new_priority = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 20));
    c.new_sleeping = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 1048575)) : 20'd0;
    c.new_blocked = ($urandom_range(0, 5) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 30) c.action = ACT_LOAD;
    else if (pick < 50) c.action = ACT_WAIT;
    else if (pick < 70) c.action = ACT_SIGNAL;
    else if (pick < 80) c.action = ACT_SLEEP;
    else if (pick < 95) c.action = ACT_RESCHED;
    else c.action = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
    return c;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    apply_config(idx, val);
  endtask

  task automatic configure(logic [9:0] sa, logic [9:0] sb, logic [9:0] sc, logic [9:0] sd,
                           logic [9:0] rate);
    write_reg(CFG_SEM_A, sa);
    write_reg(CFG_SEM_A + 3'd1, sb);
    write_reg(CFG_SEM_A + 3'd2, sc);
    write_reg(CFG_SEM_D, sd);
    write_reg(CFG_TICK_RATE, rate);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_calls.size() > 0 || in_if.valid || expected_results.size() > 0);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SEM_A;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.action = ACT_RESCHED;
    in_if.sem_index = '0;
    in_if.sleep_ms = '0;
    in_if.proc_index = '0;
    in_if.new_ticks = '0;
    in_if.new_priority = '0;
    in_if.new_sleeping = '0;
    in_if.new_blocked = 1'b0;
    out_if.ready = 1'b0;
    for (int i = 0; i < NPROC; i++) begin
      slice_left[i] = '0;
      slice_refill[i] = '0;
      sleep_left[i] = '0;
      proc_blocked[i] = 1'b0;
    end
    running_idx = '0;
    tick_rate = 100;
    for (int s = 0; s < NSEM; s++) apply_config(CFG_SEM_A + 3'(s), 10'd1);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    pending_calls.push_back(make_call(ACT_RESCHED, 0, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_SLEEP, 0, 16'd65535, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_WAIT, 2'd0, 0, 0, 0, 0, 0, 0));
    drain();
    configure(10'd0, 10'd8, 10'd1, 10'd0, 10'd1);
    drain();

    pending_calls.push_back(make_call(ACT_LOAD, 0, 0, 3'd0, 16'd65535, 16'd65535, 0, 0));
    pending_calls.push_back(make_call(ACT_LOAD, 0, 0, 3'd7, 16'd0, 16'd65535, 0, 0));
    pending_calls.push_back(make_call(ACT_LOAD, 0, 0, 3'd3, 16'd0, 16'd5, 20'hFFFFF, 1'b1));
    pending_calls.push_back(make_call(ACT_LOAD, 0, 0, 3'd4, 16'd1, 16'd1, 0, 0));
    pending_calls.push_back(make_call(ACT_RESCHED, 0, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_WAIT, 2'd0, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_WAIT, 2'd0, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_SIGNAL, 2'd0, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_SIGNAL, 2'd0, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_WAIT, 2'd1, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_SIGNAL, 2'd3, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_SLEEP, 0, 16'd999, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_SLEEP, 0, 16'd65535, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_RESCHED, 0, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_UNUSED_FIRST, 0, 0, 0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_UNUSED_LAST, 2'd3, 16'hFFFF, 3'd7, 16'hFFFF,
                                      16'hFFFF, 20'hFFFFF, 1'b1));
    pending_calls.push_back(make_call(ACT_LOAD, 0, 0, 3'd0, 0, 0, 0, 0));
    pending_calls.push_back(make_call(ACT_RESCHED, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 250; i++) pending_calls.push_back(random_call());
    drain();

    configure(10'd8, 10'd0, 10'd8, 10'd3, 10'd1000);
    for (int i = 0; i < 250; i++) pending_calls.push_back(random_call());
    drain();

    configure(10'($urandom_range(0, 8)), 10'($urandom_range(0, 8)),
              10'($urandom_range(0, 8)), 10'($urandom_range(0, 8)),
              10'($urandom_range(1, 1000)));
    for (int i = 0; i < 250; i++) pending_calls.push_back(random_call());
    drain();

    idling_on = 0;
    configure(10'd1, 10'd2, 10'd0, 10'd8, 10'd100);
    for (int i = 0; i < 250; i++) pending_calls.push_back(random_call());
    drain();

    if (errors == 0) begin
      $display("semaphore_fifo_tick_scheduler_core: match");
    end else begin
      $display("semaphore_fifo_tick_scheduler_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("semaphore_fifo_tick_scheduler_core: mismatch");
    $finish;
  end
endmodule

/* sim.f */
design/sfts_pkg.sv
design/sfts_if.sv
design/sfts_scan.sv
design/semaphore_fifo_tick_scheduler_core.sv
test/testbench.sv
